>>> rtl/core/osa_edit_distance_macros.svh
// ----------------------------------------------------------------------------
// OSA edit distance assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef OSA_EDIT_DISTANCE_MACROS_SVH
`define OSA_EDIT_DISTANCE_MACROS_SVH

// same-cycle implication, disabled in reset
`define OSA_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define OSA_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/osa_pkg.sv
// ----------------------------------------------------------------------------
// OSA package
// Shared constants and types of the OSA edit distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package osa_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int SYM_W       = 8;
  localparam int DIST_W      = 7;
  localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

  // control bits that travel with a symbol along the cell chain
  typedef struct packed {
    logic valid;
    logic last;
  } tok_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/osa_in_if.sv
// ----------------------------------------------------------------------------
// OSA input channel
// Valid/ready channel carrying one string byte item.
// ----------------------------------------------------------------------------
`default_nettype none

interface osa_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [osa_pkg::SYM_W-1:0] symbol;
  logic                      has_symbol;
  logic                      last;

  modport source (output valid, mode, symbol, has_symbol, last, input ready);
  modport sink   (input valid, mode, symbol, has_symbol, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/osa_out_if.sv
// ----------------------------------------------------------------------------
// OSA result channel
// Valid/ready channel carrying one distance item.
// ----------------------------------------------------------------------------
`default_nettype none

interface osa_out_if;
  logic                       valid;
  logic                       ready;
  logic [osa_pkg::DIST_W-1:0] distance;
  logic                       overflow;

  modport source (output valid, distance, overflow, input ready);
  modport sink   (input valid, distance, overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/core/osa_ram.sv
// ----------------------------------------------------------------------------
// OSA generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module osa_ram #(
  parameter int WIDTH = osa_pkg::SYM_W,
  parameter int DEPTH = osa_pkg::MAX_LEN_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/osa_cell.sv
// ----------------------------------------------------------------------------
// OSA cell
// One row of the cost table: holds one byte of the first string and turns
// each streamed byte of the second string into the next cost of its row.
// ----------------------------------------------------------------------------
`default_nettype none

module osa_cell #(
  parameter int MAX_LEN = osa_pkg::MAX_LEN_DEF,
  parameter int IDX     = 0
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic                              active,
  input  wire logic                              wr_en,
  input  wire logic [osa_pkg::SYM_W-1:0]         wr_sym,
  input  wire logic [osa_pkg::SYM_W-1:0]         a_prev,
  output logic      [osa_pkg::SYM_W-1:0]         a_o,
  input  wire osa_pkg::tok_ctl_t                 ctl_i,
  input  wire logic [osa_pkg::SYM_W-1:0]         b_i,
  input  wire logic [$clog2(MAX_LEN+1)-1:0]      d_i,
  input  wire logic [$clog2(MAX_LEN+1)-1:0]      dp_i,
  output osa_pkg::tok_ctl_t                      ctl_o,
  output logic      [osa_pkg::SYM_W-1:0]         b_o,
  output logic      [$clog2(MAX_LEN+1)-1:0]      d_o,
  output logic      [$clog2(MAX_LEN+1)-1:0]      dp_o
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam logic [LW-1:0] ROW    = LW'(IDX + 1);
  localparam logic [LW-1:0] ROW_UP = LW'(IDX);

  logic [osa_pkg::SYM_W-1:0] a_r, b_prev_r, b_o_r;
  logic [LW-1:0]             left_r, up_prev_r, dp_prev_r, d_o_r, dp_o_r;
  logic                      started_r;
  osa_pkg::tok_ctl_t         ctl_o_r;

  logic [LW:0]   c_up, c_left, c_diag, c_swap, m1, m2, m3;
  logic          swap_ok;
  logic [LW-1:0] d_val;

  // up_prev holds D[i-1][j-1], dp_prev holds D[i-2][j-2]
  always_comb begin
    c_up    = {1'b0, d_i} + {{LW{1'b0}}, 1'b1};
    c_left  = {1'b0, left_r} + {{LW{1'b0}}, 1'b1};
    c_diag  = {1'b0, up_prev_r} + {{LW{1'b0}}, (a_r != b_i)};
    c_swap  = {1'b0, dp_prev_r} + {{LW{1'b0}}, 1'b1};
    swap_ok = (IDX != 0) && started_r && (a_r == b_prev_r) && (a_prev == b_i);
    m1      = (c_up < c_left) ? c_up : c_left;
    m2      = (c_diag < m1) ? c_diag : m1;
    m3      = (swap_ok && (c_swap < m2)) ? c_swap : m2;
    // rows past the first string's end pass the cost through
    d_val   = active ? m3[LW-1:0] : d_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o_r   <= '0;
      started_r <= 1'b0;
    end else begin
      ctl_o_r <= ctl_i;
      if (start) begin
        started_r <= 1'b0;
      end else if (ctl_i.valid) begin
        started_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      a_r <= wr_sym;
    end
    if (start) begin
      left_r    <= ROW;
      up_prev_r <= ROW_UP;
    end else if (ctl_i.valid) begin
      left_r    <= d_val;
      up_prev_r <= d_i;
      dp_prev_r <= dp_i;
      b_prev_r  <= b_i;
    end
    if (ctl_i.valid) begin
      d_o_r  <= d_val;
      dp_o_r <= up_prev_r;
      b_o_r  <= b_i;
    end
  end

  assign a_o   = a_r;
  assign ctl_o = ctl_o_r;
  assign b_o   = b_o_r;
  assign d_o   = d_o_r;
  assign dp_o  = dp_o_r;

endmodule

`default_nettype wire

>>> rtl/core/osa_edit_distance.sv
// ----------------------------------------------------------------------------
// OSA edit distance
// Optimal string alignment distance between two byte strings on a cell chain.
// ----------------------------------------------------------------------------
// Bytes of either string load at one item per clock while the block is
// idle: first-string bytes go into the cells of the chain (one cell per
// position), second-string bytes go into a RAM. The item with last set on
// the second string starts the computation; in_ready stays low until the
// result has been placed in the output register, once that register is
// free, after the second string has streamed through all MAX_LEN cells.
// If either string is empty the result is the other string's length and
// the chain is not run. No clearing pass is needed after reset.
// Bytes beyond MAX_LEN are dropped and flagged in overflow. The first string
// stays loaded, so further second strings may be compared against it.
`default_nettype none

module osa_edit_distance #(
  parameter int MAX_LEN = osa_pkg::MAX_LEN_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  osa_in_if.sink      in_chan,
  osa_out_if.source   out_chan
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int RW = (LW > osa_pkg::DIST_W) ? LW : osa_pkg::DIST_W;
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [LW-1:0] len1_r, len1_nxt, len2_r, len2_nxt;
  logic          trunc1_r, trunc1_nxt, trunc2_r, trunc2_nxt;
  logic          closed1_r, closed1_nxt, closed2_r, closed2_nxt;
  logic [LW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [LW-1:0] res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [osa_pkg::DIST_W-1:0] distance_r;
  logic          overflow_r;
  osa_pkg::tok_ctl_t feed_ctl_r, feed_ctl_nxt;
  logic [LW-1:0] feed_j_r;

  logic          accept, start, issue, load_out;
  logic [LW-1:0] eff_len1, eff_len2;
  logic          wr1, wr2;
  logic [RW-1:0] res_w;
  logic [osa_pkg::SYM_W-1:0] ram_rdata;

  logic [MAX_LEN-1:0] cell_we, cell_act;
  logic [osa_pkg::SYM_W-1:0] a_c  [MAX_LEN+1];
  logic [osa_pkg::SYM_W-1:0] b_c  [MAX_LEN+1];
  logic [LW-1:0]             d_c  [MAX_LEN+1];
  logic [LW-1:0]             dp_c [MAX_LEN+1];
  osa_pkg::tok_ctl_t         ctl_c [MAX_LEN+1];

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept   = in_chan.valid && in_chan.ready;
  // a closed string restarts empty on its next item
  assign eff_len1 = closed1_r ? '0 : len1_r;
  assign eff_len2 = closed2_r ? '0 : len2_r;
  assign wr1 = accept && !in_chan.mode && in_chan.has_symbol && (eff_len1 < LEN_MAX);
  assign wr2 = accept && in_chan.mode && in_chan.has_symbol && (eff_len2 < LEN_MAX);
  assign start    = (state_r == ST_START) && (len1_r != '0) && (len2_r != '0);
  assign issue    = (state_r == ST_RUN) && (rd_cnt_r < len2_r);
  assign load_out = (state_r == ST_HOLD) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt    = state_r;
    len1_nxt     = len1_r;
    len2_nxt     = len2_r;
    trunc1_nxt   = trunc1_r;
    trunc2_nxt   = trunc2_r;
    closed1_nxt  = closed1_r;
    closed2_nxt  = closed2_r;
    rd_cnt_nxt   = rd_cnt_r;
    res_nxt      = res_r;
    feed_ctl_nxt = '0;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && !in_chan.mode) begin
          len1_nxt    = eff_len1 + LW'(wr1);
          trunc1_nxt  = (closed1_r ? 1'b0 : trunc1_r) ||
                        (in_chan.has_symbol && !wr1);
          closed1_nxt = in_chan.last;
        end else if (accept) begin
          len2_nxt    = eff_len2 + LW'(wr2);
          trunc2_nxt  = (closed2_r ? 1'b0 : trunc2_r) ||
                        (in_chan.has_symbol && !wr2);
          closed2_nxt = in_chan.last;
          if (in_chan.last) begin
            closed1_nxt = 1'b1;
            state_nxt   = ST_START;
          end
        end
      end
      ST_START: begin
        rd_cnt_nxt = '0;
        if (start) begin
          state_nxt = ST_RUN;
        end else begin
          res_nxt   = (len1_r == '0) ? len2_r : len1_r;
          state_nxt = ST_HOLD;
        end
      end
      ST_RUN: begin
        if (issue) begin
          rd_cnt_nxt         = rd_cnt_r + LW'(1);
          feed_ctl_nxt.valid = 1'b1;
          feed_ctl_nxt.last  = ((rd_cnt_r + LW'(1)) == len2_r);
        end
        if (ctl_c[MAX_LEN].valid && ctl_c[MAX_LEN].last) begin
          res_nxt   = d_c[MAX_LEN];
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len1_r      <= '0;
      len2_r      <= '0;
      trunc1_r    <= 1'b0;
      trunc2_r    <= 1'b0;
      closed1_r   <= 1'b1;
      closed2_r   <= 1'b1;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
      feed_ctl_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      len1_r      <= len1_nxt;
      len2_r      <= len2_nxt;
      trunc1_r    <= trunc1_nxt;
      trunc2_r    <= trunc2_nxt;
      closed1_r   <= closed1_nxt;
      closed2_r   <= closed2_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      feed_ctl_r  <= feed_ctl_nxt;
    end
  end

  // saturate for chains longer than the result field can count
  assign res_w = RW'(res_r);

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (issue) begin
      feed_j_r <= rd_cnt_r + LW'(1);
    end
    if (load_out) begin
      distance_r <= (res_w > RW'(osa_pkg::DIST_MAX)) ? osa_pkg::DIST_MAX :
                    res_w[osa_pkg::DIST_W-1:0];
      overflow_r <= trunc1_r || trunc2_r;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.distance = distance_r;
  assign out_chan.overflow = overflow_r;

  osa_ram #(
    .WIDTH (osa_pkg::SYM_W),
    .DEPTH (MAX_LEN)
  ) u_second_ram (
    .clk   (clk),
    .we    (wr2),
    .waddr (eff_len2[AW-1:0]),
    .wdata (in_chan.symbol),
    .raddr (rd_cnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // head of the chain: top row of the table, D[0][j] = j
  assign a_c[0]   = '0;
  assign ctl_c[0] = feed_ctl_r;
  assign b_c[0]   = ram_rdata;
  assign d_c[0]   = feed_j_r;
  assign dp_c[0]  = '0;

  genvar k;
  generate
    for (k = 0; k < MAX_LEN; k++) begin : g_cell
      assign cell_we[k]  = wr1 && (eff_len1[AW-1:0] == AW'(k));
      assign cell_act[k] = (LW'(k) < len1_r);

      osa_cell #(
        .MAX_LEN (MAX_LEN),
        .IDX     (k)
      ) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .active (cell_act[k]),
        .wr_en  (cell_we[k]),
        .wr_sym (in_chan.symbol),
        .a_prev (a_c[k]),
        .a_o    (a_c[k+1]),
        .ctl_i  (ctl_c[k]),
        .b_i    (b_c[k]),
        .d_i    (d_c[k]),
        .dp_i   (dp_c[k]),
        .ctl_o  (ctl_c[k+1]),
        .b_o    (b_c[k+1]),
        .d_o    (d_c[k+1]),
        .dp_o   (dp_c[k+1])
      );
    end
  endgenerate

endmodule

`default_nettype wire

>>> rtl/core/osa_checker.sv
// ----------------------------------------------------------------------------
// OSA checker
// Port-level assertions on the OSA edit distance block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "osa_edit_distance_macros.svh"

module osa_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       in_mode,
  input wire logic                       in_last,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [osa_pkg::DIST_W-1:0] out_distance,
  input wire logic                       out_overflow
);

  `OSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result item dropped while stalled")
  `OSA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_distance) && $stable(out_overflow), "result payload changed while stalled")
  `OSA_ASSERT_NEXT(a_busy_after_end, in_valid && in_ready && in_mode && in_last, !in_ready, "input taken during computation")
  `OSA_ASSERT_NOW(a_result_after_busy, $rose(out_valid), $past(!in_ready), "result without a computation phase")

endmodule

bind osa_edit_distance osa_checker u_osa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_mode      (in_chan.mode),
  .in_last      (in_chan.last),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_distance (out_chan.distance),
  .out_overflow (out_chan.overflow)
);

`default_nettype wire
